>>> hw/rtl/itrd_pkg.sv
`default_nettype none
package itrd_pkg;

  // Field widths
  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;

  // Digit store: remainders, least significant first
  localparam int STORE_DEPTH = VALUE_BITS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Divider: STEP_BITS quotient bits are produced per cycle
  localparam int STEP_BITS  = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W      = DIV_STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Base limits and character offsets
  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
  localparam logic [CHAR_W-1:0]  ALPHA_OFFSET = CHAR_W'(55);
  localparam logic [CHAR_W-1:0]  NUM_OFFSET   = CHAR_W'(48);
  localparam logic [RADIX_W-1:0] NUM_TOP      = RADIX_W'(9);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic                  zero;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_PUT
  } back_state_t;

  // Digit value to upper-case ASCII
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > NUM_TOP) begin
      c = CHAR_W'(d) + ALPHA_OFFSET;
    end else begin
      c = CHAR_W'(d) + NUM_OFFSET;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/itrd_front.sv
`default_nettype none
module itrd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire itrd_pkg::in_t  in_data,
  output logic                item_valid,
  output itrd_pkg::item_t     item,
  input  wire logic           item_take
);

  // Two-entry item queue
  itrd_pkg::item_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  itrd_pkg::item_t cls;
  logic            do_push;
  logic            do_pop;

  // Clamp the base to 2..36 and flag a zero value
  always_comb begin
    cls.value = in_data.value;
    if (in_data.radix < itrd_pkg::RADIX_MIN) begin
      cls.radix = itrd_pkg::RADIX_MIN;
    end else if (in_data.radix > itrd_pkg::RADIX_MAX) begin
      cls.radix = itrd_pkg::RADIX_MAX;
    end else begin
      cls.radix = in_data.radix;
    end
    cls.zero = (in_data.value == '0);
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/itrd_out_q.sv
`default_nettype none
module itrd_out_q (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_push,
  input  wire itrd_pkg::out_t res_data,
  output logic                res_full,
  output logic                empty,
  input  wire logic           pop,
  output itrd_pkg::out_t      out_data
);

  // Two-entry result queue
  itrd_pkg::out_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_data = q_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/itrd_back.sv
`default_nettype none
module itrd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire itrd_pkg::item_t item,
  output logic                 item_take,
  output logic                 res_push,
  output itrd_pkg::out_t       res_data,
  input  wire logic            res_full
);

  localparam int DW = itrd_pkg::DIV_W;
  localparam int SB = itrd_pkg::STEP_BITS;
  localparam int RW = itrd_pkg::RADIX_W;
  localparam int AW = itrd_pkg::ADDR_W;
  localparam int CW = itrd_pkg::STEP_CNT_W;

  itrd_pkg::back_state_t state_r, state_nxt;

  logic [DW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] radix_r, radix_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  // Digit store
  logic [RW-1:0] store [itrd_pkg::STORE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic [RW-1:0] rd_data_r;

  // One divider step: STEP_BITS restoring iterations on a narrow remainder
  logic [RW-1:0] rem_step;
  logic [SB-1:0] qbits;
  logic [DW-1:0] quo_step;
  logic [RW:0]   trial;

  always_comb begin
    rem_step = rem_r;
    qbits    = '0;
    trial    = '0;
    for (int i = 0; i < SB; i++) begin
      trial = {rem_step, quo_r[DW-1-i]};
      if (trial >= {1'b0, radix_r}) begin
        rem_step       = RW'(trial - {1'b0, radix_r});
        qbits[SB-1-i]  = 1'b1;
      end else begin
        rem_step = trial[RW-1:0];
      end
    end
    quo_step = {quo_r[DW-SB-1:0], qbits};
  end

  // Sequencer: divide, store remainders, then read them back in reverse
  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    item_take = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt_r;
    wr_data   = rem_step;
    res_push  = 1'b0;
    res_data.digit_char = itrd_pkg::digit_to_ascii(rd_data_r);
    res_data.last       = (idx_r == '0);

    case (state_r)
      itrd_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          radix_nxt = item.radix;
          quo_nxt   = DW'(item.value);
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          if (item.zero) begin
            // Zero gives the single digit '0'
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '0;
            cnt_nxt   = AW'(1);
            idx_nxt   = '0;
            state_nxt = itrd_pkg::ST_READ;
          end else begin
            state_nxt = itrd_pkg::ST_DIV;
          end
        end
      end
      itrd_pkg::ST_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + CW'(1);
        if (step_r == CW'(itrd_pkg::DIV_STEPS - 1)) begin
          // Digit done: store the remainder
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r + AW'(1);
          rem_nxt  = '0;
          step_nxt = '0;
          if (quo_step == '0) begin
            idx_nxt   = cnt_r;
            state_nxt = itrd_pkg::ST_READ;
          end
        end
      end
      itrd_pkg::ST_READ: begin
        state_nxt = itrd_pkg::ST_PUT;
      end
      itrd_pkg::ST_PUT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (idx_r == '0) begin
            state_nxt = itrd_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = itrd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = itrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itrd_pkg::ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  // Store write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data_r <= store[idx_r];
  end

endmodule
`default_nettype wire

>>> hw/rtl/integer_to_radix_digits_top.sv
`default_nettype none
// Converts a non-negative 31-bit value to its digits in a base from 2 to 36
// (bases outside that range are clamped), giving one result per digit, most
// significant first, as upper-case ASCII with last set on the final digit;
// zero gives the single digit '0'. Both sides are queues: an item transfers
// on push with full low, a digit transfers on pop with empty low. A two-entry
// item queue lets the next item be accepted while the current one is worked
// on. The converter takes an item, then works out each digit in the divider,
// which retires 8 quotient bits per cycle, storing the remainders in the digit
// store, and then reads each digit back through the registered read port of
// the digit store and hands it on. A zero value skips the divider.
// Back-pressure on the result side stalls the converter for as long as the
// result queue stays full.
module integer_to_radix_digits_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire itrd_pkg::in_t  in_data,
  output logic                empty,
  input  wire logic           pop,
  output itrd_pkg::out_t      out_data
);

  logic            item_valid;
  itrd_pkg::item_t item;
  logic            item_take;
  logic            res_push;
  itrd_pkg::out_t  res_data;
  logic            res_full;

  itrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  itrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_push   (res_push),
    .res_data   (res_data),
    .res_full   (res_full)
  );

  itrd_out_q u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> tb/integer_to_radix_digits_checker.sv
`timescale 1ns / 1ps
// Watches both queue interfaces of the digit converter. Each accepted value is
// turned into its expected digit string, and each popped digit is compared with
// the oldest digit still due.
module integer_to_radix_digits_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           full,
  input  itrd_pkg::in_t  in_data,
  input  logic           empty,
  input  logic           pop,
  input  itrd_pkg::out_t out_data,
  output int             fail_count,
  output int             pending,
  output int             digits_seen
);
  import itrd_pkg::*;

  out_t due_digits[$];
  out_t want;

  initial begin
    fail_count  = 0;
    pending     = 0;
    digits_seen = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] digit mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Repeated division by the clamped base; remainders come out LSD first,
  // so they are queued in reverse
  function automatic void predict_digits(input in_t it);
    logic [RADIX_W-1:0]    base;
    logic [VALUE_BITS-1:0] quot;
    logic [RADIX_W-1:0]    rems[STORE_DEPTH];
    int                    n;
    out_t                  d;
    base = it.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    quot = it.value;
    n = 0;
    // zero still gives one digit
    if (quot == '0) begin
      rems[0] = '0;
      n = 1;
    end
    while (quot != '0) begin
      rems[n] = RADIX_W'(quot % base);
      quot = quot / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] > NUM_TOP) begin
        d.digit_char = CHAR_W'(rems[k]) + ALPHA_OFFSET;
      end else begin
        d.digit_char = CHAR_W'(rems[k]) + NUM_OFFSET;
      end
      d.last = (k == 0);
      due_digits.push_back(d);
    end
  endfunction

  // Result side first: a digit can never leave in the cycle its value arrives
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        digits_seen++;
        if (due_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                    out_data.digit_char, out_data.last));
        end else begin
          want = due_digits.pop_front();
          if (out_data.digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char got %0d want %0d",
                                      out_data.digit_char, want.digit_char));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b (char %0d)",
                                      out_data.last, want.last, want.digit_char));
          end
        end
      end
      if (push && !full) begin
        predict_digits(in_data);
      end
    end
    pending <= due_digits.size();
  end

endmodule

>>> tb/integer_to_radix_digits_top_tb.sv
`timescale 1ns / 1ps
module integer_to_radix_digits_top_tb;
  import itrd_pkg::*;

  localparam int RANDOM_ITEMS = 290;
  localparam int CALM_ITEMS   = 40;
  localparam int HOLD_AT      = 60;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [VALUE_BITS-1:0] MAXV = {VALUE_BITS{1'b1}};

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_t  in_data;
  logic empty;
  logic pop;
  out_t out_data;

  int fail_count;
  int pending;
  int digits_seen;
  int sent;
  int cycle_count;
  bit calm;
  bit held;

  integer_to_radix_digits_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  integer_to_radix_digits_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .digits_seen (digits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digits still due", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_t item_of(input logic [VALUE_BITS-1:0] v,
                                  input logic [RADIX_W-1:0] r);
    in_t it;
    it.value = v;
    it.radix = r;
    return it;
  endfunction

  // Mostly legal bases; values spread over size classes and base powers
  function automatic in_t random_item();
    in_t                   it;
    logic [VALUE_BITS-1:0] p;
    int unsigned           b;
    int                    k;
    if ($urandom_range(0, 99) < 85) begin
      it.radix = RADIX_W'($urandom_range(2, 36));
    end else begin
      it.radix = RADIX_W'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.value = VALUE_BITS'($urandom);
      4, 5, 6:    it.value = VALUE_BITS'($urandom_range(0, 2000));
      7:          it.value = VALUE_BITS'($urandom >> $urandom_range(1, 31));
      8: begin
        case ($urandom_range(0, 2))
          0:       it.value = '0;
          1:       it.value = MAXV;
          default: it.value = VALUE_BITS'(1) << $urandom_range(0, 30);
        endcase
      end
      default: begin
        // a power of the base, or one below it, where the digit count steps
        b = it.radix;
        if (b < RADIX_MIN) b = RADIX_MIN;
        if (b > RADIX_MAX) b = RADIX_MAX;
        p = VALUE_BITS'(1);
        k = $urandom_range(1, 30);
        while (k > 0 && p <= MAXV / b) begin
          p = VALUE_BITS'(p * b);
          k--;
        end
        it.value = $urandom_range(0, 1) ? p : p - 1'b1;
      end
    endcase
    return it;
  endfunction

  // Offer one value, with an occasional idle burst before it
  task automatic send_item(input in_t it);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Receiver: random stall bursts plus one long hold-off to back the block up
  initial begin
    int stall_left;
    int hold_left;
    pop        = 1'b0;
    held       = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!held && sent >= HOLD_AT) begin
          held      = 1'b1;
          hold_left = LONG_HOLD;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    sent    = 0;
    calm    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero in several bases, including clamped ones
    send_item(item_of('0, 6'd10));
    send_item(item_of('0, 6'd2));
    send_item(item_of('0, 6'd36));
    send_item(item_of('0, 6'd0));
    // largest value: longest string in base two, shortest in base 36
    send_item(item_of(MAXV, 6'd2));
    send_item(item_of(MAXV, 6'd36));
    send_item(item_of(MAXV, 6'd10));
    send_item(item_of(MAXV, 6'd16));
    // bases below two and above 36 saturate
    send_item(item_of(MAXV, 6'd63));
    send_item(item_of(MAXV, 6'd1));
    send_item(item_of(31'd1, 6'd0));
    send_item(item_of(31'd1, 6'd37));
    send_item(item_of(31'd123456789, 6'd37));
    // digit/letter boundary: '9', 'A', 'Z'
    send_item(item_of(31'd9, 6'd10));
    send_item(item_of(31'd10, 6'd16));
    send_item(item_of(31'd35, 6'd36));
    send_item(item_of(31'd1295, 6'd36));
    send_item(item_of(31'd36, 6'd36));
    send_item(item_of(31'd1, 6'd2));
    send_item(item_of(31'h4000_0000, 6'd2));
    send_item(item_of(31'h2AAA_AAAA, 6'd2));
    send_item(item_of(31'h5555_5555, 6'd3));
    send_item(item_of(31'd7, 6'd63));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      send_item(random_item());
    end
    push <= 1'b0;

    // wait for every due digit, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values to %0d digits; bases 0..63 incl. clamped, zero and full range",
             sent, digits_seen);
    $display("input and output idle bursts, one %0d-cycle output hold-off, %0d mismatches",
             LONG_HOLD, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/itrd_pkg.sv
hw/rtl/itrd_front.sv
hw/rtl/itrd_out_q.sv
hw/rtl/itrd_back.sv
hw/rtl/integer_to_radix_digits_top.sv
tb/integer_to_radix_digits_checker.sv
tb/integer_to_radix_digits_top_tb.sv
